// File: design/pwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and codes of the wire-format tokenizer: beat payloads, token
// kinds, error codes, decode phases and the record passed through the queue.
// ----------------------------------------------------------------------------
package pwt_pkg;

  localparam int QueueDepth = 4;

  // token kinds
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VARINT  = 3'd1;
  localparam logic [2:0] KIND_FIXED32 = 3'd2;
  localparam logic [2:0] KIND_FIXED64 = 3'd3;
  localparam logic [2:0] KIND_LENGTH  = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_FIELD_ZERO = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
  localparam logic [2:0] ERR_BAD_WIRE   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
  localparam logic [2:0] ERR_OVERRUN    = 3'd5;

  // wire types
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENGTH  = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  localparam logic [3:0] FIXED_LAST_IDX  = 4'd7;

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIX32   = 3'd2,
    PH_FIX64   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_beat_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] token_value;
    logic [2:0]  error_code;
    logic        message_end;
    logic        last_result;
  } token_beat_t;

  // one accepted byte's results: a token, optionally followed by an error
  typedef struct packed {
    token_beat_t first;
    logic        has_err;
    logic [2:0]  err_code;
  } rec_t;

endpackage

// File: design/pwt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_fifo
// Small register queue of per-byte result records between the decoder front
// and the output sequencer.
// ----------------------------------------------------------------------------
module pwt_fifo #(
  parameter int DEPTH = pwt_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pwt_pkg::rec_t push_data,
  output logic          full,
  input  logic          pop,
  output pwt_pkg::rec_t pop_data,
  output logic          empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pwt_pkg::rec_t        mem [DEPTH];
  logic [PtrW-1:0]      head;
  logic [PtrW-1:0]      tail;
  logic [CntW-1:0]      count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PtrW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PtrW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/pwt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_front
// Byte decoder: varint and fixed assembly, key split, length tracking and
// error hold. Each accepted byte yields at most one queue record.
// ----------------------------------------------------------------------------
module pwt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  pwt_pkg::byte_beat_t byte_data,
  input  logic                queue_full,
  output logic                byte_ready,
  output logic                push,
  output pwt_pkg::rec_t       rec
);

  pwt_pkg::phase_t phase, phase_next;
  logic [3:0]      byte_count, byte_count_next;
  logic [63:0]     accumulator, accumulator_next;
  logic [31:0]     current_field, current_field_next;
  logic [2:0]      current_wire, current_wire_next;
  logic [63:0]     payload_left, payload_left_next;
  logic            error_hold, error_hold_next;

  logic [7:0]  b;
  logic        eom;
  logic        accept;
  logic [3:0]  vidx;
  logic [5:0]  vshift;
  logic [63:0] vacc;
  logic        v_done, v_long, v_trunc;
  logic [2:0]  fidx;
  logic [63:0] facc;
  logic [3:0]  fcount;
  logic        f_done;
  logic [63:0] pl_dec;
  logic [31:0] key_field;
  logic [2:0]  key_wire;
  logic        wire_ok;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_data.data_byte;
  assign eom        = byte_data.end_of_message;

  // varint byte lands 7 bits at a time, index saturates at the tenth byte
  assign vidx    = (byte_count > pwt_pkg::VARINT_LAST_IDX) ? pwt_pkg::VARINT_LAST_IDX
                                                            : byte_count;
  assign vshift  = 6'(vidx) * 6'd7;
  assign vacc    = accumulator | (64'(b[6:0]) << vshift);
  assign v_done  = !b[7];
  assign v_long  = b[7] && (vidx >= pwt_pkg::VARINT_LAST_IDX);
  assign v_trunc = b[7] && (vidx < pwt_pkg::VARINT_LAST_IDX) && eom;

  assign fidx   = (byte_count > pwt_pkg::FIXED_LAST_IDX) ? 3'(pwt_pkg::FIXED_LAST_IDX)
                                                          : byte_count[2:0];
  assign facc   = accumulator | (64'(b) << {fidx, 3'b000});
  assign fcount = {1'b0, fidx} + 4'd1;
  assign f_done = (phase == pwt_pkg::PH_FIX32) ? (fcount >= 4'd4) : (fcount >= 4'd8);

  assign pl_dec = (payload_left != '0) ? payload_left - 64'd1 : '0;

  assign key_field = vacc[34:3];
  assign key_wire  = vacc[2:0];
  assign wire_ok   = (key_wire == pwt_pkg::WIRE_VARINT) || (key_wire == pwt_pkg::WIRE_FIXED64)
                  || (key_wire == pwt_pkg::WIRE_LENGTH) || (key_wire == pwt_pkg::WIRE_FIXED32);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pwt_pkg::PH_KEY;
      byte_count    <= '0;
      accumulator   <= '0;
      current_field <= '0;
      current_wire  <= '0;
      payload_left  <= '0;
      error_hold    <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      accumulator   <= accumulator_next;
      current_field <= current_field_next;
      current_wire  <= current_wire_next;
      payload_left  <= payload_left_next;
      error_hold    <= error_hold_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    accumulator_next   = accumulator;
    current_field_next = current_field;
    current_wire_next  = current_wire;
    payload_left_next  = payload_left;
    error_hold_next    = error_hold;
    push               = 1'b0;
    rec.first.token_kind   = pwt_pkg::KIND_ERROR;
    rec.first.field_number = current_field;
    rec.first.wire_type    = current_wire;
    rec.first.token_value  = '0;
    rec.first.error_code   = pwt_pkg::ERR_NONE;
    rec.first.message_end  = eom;
    rec.first.last_result  = 1'b1;
    rec.has_err            = 1'b0;
    rec.err_code           = pwt_pkg::ERR_NONE;

    // on each accepted byte, decode by phase and push a record when a token or error results
    if (accept) begin
      if (error_hold) begin
        if (eom) begin
          phase_next         = pwt_pkg::PH_KEY;
          byte_count_next    = '0;
          accumulator_next   = '0;
          current_field_next = '0;
          current_wire_next  = '0;
          payload_left_next  = '0;
          error_hold_next    = 1'b0;
        end
      end else begin
        unique case (phase)
          pwt_pkg::PH_VARINT, pwt_pkg::PH_LENGTH: begin
            if (v_long || v_trunc) begin
              push                 = 1'b1;
              rec.first.error_code = v_long ? pwt_pkg::ERR_TOO_LONG : pwt_pkg::ERR_TRUNCATED;
              byte_count_next      = '0;
              accumulator_next     = '0;
              error_hold_next      = !eom;
            end else if (v_done) begin
              push                  = 1'b1;
              rec.first.token_value = vacc;
              byte_count_next       = '0;
              accumulator_next      = '0;
              phase_next            = pwt_pkg::PH_KEY;
              if (phase == pwt_pkg::PH_VARINT) begin
                rec.first.token_kind = pwt_pkg::KIND_VARINT;
              end else begin
                rec.first.token_kind = pwt_pkg::KIND_LENGTH;
                if (vacc != '0) begin
                  if (eom) begin
                    rec.has_err  = 1'b1;
                    rec.err_code = pwt_pkg::ERR_OVERRUN;
                  end else begin
                    payload_left_next = vacc;
                    phase_next        = pwt_pkg::PH_PAYLOAD;
                  end
                end
              end
            end else begin
              accumulator_next = vacc;
              byte_count_next  = vidx + 4'd1;
            end
          end
          pwt_pkg::PH_FIX32, pwt_pkg::PH_FIX64: begin
            if (f_done) begin
              push                  = 1'b1;
              rec.first.token_kind  = (phase == pwt_pkg::PH_FIX32) ? pwt_pkg::KIND_FIXED32
                                                                   : pwt_pkg::KIND_FIXED64;
              rec.first.token_value = facc;
              byte_count_next       = '0;
              accumulator_next      = '0;
              phase_next            = pwt_pkg::PH_KEY;
            end else if (eom) begin
              push                 = 1'b1;
              rec.first.error_code = pwt_pkg::ERR_TRUNCATED;
              byte_count_next      = '0;
              accumulator_next     = '0;
            end else begin
              accumulator_next = facc;
              byte_count_next  = fcount;
            end
          end
          pwt_pkg::PH_PAYLOAD: begin
            push                  = 1'b1;
            rec.first.token_kind  = pwt_pkg::KIND_PAYLOAD;
            rec.first.token_value = 64'(b);
            payload_left_next     = pl_dec;
            if (pl_dec == '0) begin
              phase_next = pwt_pkg::PH_KEY;
            end else if (eom) begin
              rec.has_err  = 1'b1;
              rec.err_code = pwt_pkg::ERR_OVERRUN;
            end
          end
          default: begin
            if (v_long || v_trunc) begin
              push                   = 1'b1;
              rec.first.field_number = '0;
              rec.first.wire_type    = '0;
              rec.first.error_code   = v_long ? pwt_pkg::ERR_TOO_LONG
                                              : pwt_pkg::ERR_TRUNCATED;
              byte_count_next        = '0;
              accumulator_next       = '0;
              error_hold_next        = !eom;
            end else if (v_done) begin
              push                   = 1'b1;
              rec.first.field_number = key_field;
              rec.first.wire_type    = key_wire;
              byte_count_next        = '0;
              accumulator_next       = '0;
              current_field_next     = key_field;
              current_wire_next      = key_wire;
              if (key_field == '0) begin
                rec.first.error_code = pwt_pkg::ERR_FIELD_ZERO;
                error_hold_next      = !eom;
              end else if (!wire_ok) begin
                rec.first.error_code = pwt_pkg::ERR_BAD_WIRE;
                error_hold_next      = !eom;
              end else begin
                rec.first.token_kind = pwt_pkg::KIND_KEY;
                if (eom) begin
                  rec.has_err  = 1'b1;
                  rec.err_code = pwt_pkg::ERR_TRUNCATED;
                end else begin
                  case (key_wire)
                    pwt_pkg::WIRE_VARINT:  phase_next = pwt_pkg::PH_VARINT;
                    pwt_pkg::WIRE_FIXED64: phase_next = pwt_pkg::PH_FIX64;
                    pwt_pkg::WIRE_LENGTH:  phase_next = pwt_pkg::PH_LENGTH;
                    default:               phase_next = pwt_pkg::PH_FIX32;
                  endcase
                end
              end
            end else begin
              phase_next       = pwt_pkg::PH_KEY;
              accumulator_next = vacc;
              byte_count_next  = vidx + 4'd1;
            end
          end
        endcase

        // final byte always returns the decoder to its reset state
        if (eom) begin
          phase_next         = pwt_pkg::PH_KEY;
          byte_count_next    = '0;
          accumulator_next   = '0;
          current_field_next = '0;
          current_wire_next  = '0;
          payload_left_next  = '0;
          error_hold_next    = 1'b0;
        end
      end
    end
  end

endmodule

// File: design/pwt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_back
// Output sequencer: presents the head record's token, then its trailing
// error beat where there is one, and releases the record afterwards.
// ----------------------------------------------------------------------------
module pwt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  pwt_pkg::rec_t        head,
  output logic                 pop,
  output logic                 token_valid,
  input  logic                 token_ready,
  output pwt_pkg::token_beat_t token_data
);

  logic sub;
  logic beat_done;

  assign token_valid = !queue_empty;
  assign beat_done   = token_valid && token_ready;
  assign pop         = beat_done && (sub || !head.has_err);

  always_comb begin
    token_data = head.first;
    if (sub) begin
      token_data.token_kind  = pwt_pkg::KIND_ERROR;
      token_data.token_value = '0;
      token_data.error_code  = head.err_code;
      token_data.last_result = 1'b1;
    end else begin
      token_data.last_result = !head.has_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (beat_done) begin
      sub <= !sub && head.has_err;
    end
  end

endmodule

// File: design/protobuf_wire_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer
// Wire-format tokenizer: bytes of one message in, key/value/payload tokens out.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while the record queue has room and
// emits one token beat per cycle while token_ready is high. A byte is
// decoded in the cycle it is accepted; its results (one token, or a token
// followed by an error), if any, are queued as one record. Bytes giving two
// results (a key or a nonzero length on the final byte, payload cut short)
// give two output beats, and the QUEUE_DEPTH record queue lets the input keep
// running meanwhile. After an error the message yields no further tokens.
module protobuf_wire_tokenizer #(
  parameter int QUEUE_DEPTH = pwt_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  pwt_pkg::byte_beat_t  byte_data,
  output logic                 token_valid,
  input  logic                 token_ready,
  output pwt_pkg::token_beat_t token_data
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  pwt_pkg::rec_t push_rec;
  pwt_pkg::rec_t head_rec;

  pwt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .queue_full (full),
    .byte_ready (byte_ready),
    .push       (push),
    .rec        (push_rec)
  );

  pwt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_rec),
    .empty     (empty)
  );

  pwt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .head        (head_rec),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

endmodule
